// ===== rtl/tle_pkg.sv =====
package tle_pkg;

  // Line geometry
  localparam int LINE_WIDTH = 40;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int CNT_W      = 6;

  // Queue depths
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  // Character codes
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_BEL   = 8'd7;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TILDE = 8'd126;

  // Register reset values
  localparam logic [7:0] EOF_RESET    = 8'd4;
  localparam logic [7:0] ERASE_RESET  = 8'd127;
  localparam logic [7:0] KILL_RESET   = 8'd21;
  localparam logic [7:0] WERASE_RESET = 8'd23;

  typedef enum logic [1:0] {
    REG_EOF    = 2'd0,
    REG_ERASE  = 2'd1,
    REG_KILL   = 2'd2,
    REG_WERASE = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_RUBOUT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_EOF    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NEWLINE,
    OP_ERASE,
    OP_KILL,
    OP_WERASE,
    OP_PRINT,
    OP_BELL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT2
  } back_state_t;

  // Classified keystroke from the front end
  typedef struct packed {
    logic       eof_hit;
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // One result item
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
    logic             last;
  } res_t;

endpackage

// ===== rtl/tle_front.sv =====
module tle_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          push,
  input  logic [7:0]    in_byte,
  output logic          full,
  output logic          cmd_push,
  output tle_pkg::cmd_t cmd_d,
  input  logic          cmd_full
);

  logic [7:0] eof_r, erase_r, kill_r, werase_r;
  logic [7:0] eof_nxt, erase_nxt, kill_nxt, werase_nxt;

  // Decode register writes
  always_comb begin
    eof_nxt    = eof_r;
    erase_nxt  = erase_r;
    kill_nxt   = kill_r;
    werase_nxt = werase_r;
    if (cfg_we) begin
      case (tle_pkg::reg_idx_t'(cfg_index))
        tle_pkg::REG_EOF:    eof_nxt    = cfg_data;
        tle_pkg::REG_ERASE:  erase_nxt  = cfg_data;
        tle_pkg::REG_KILL:   kill_nxt   = cfg_data;
        tle_pkg::REG_WERASE: werase_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eof_r    <= tle_pkg::EOF_RESET;
      erase_r  <= tle_pkg::ERASE_RESET;
      kill_r   <= tle_pkg::KILL_RESET;
      werase_r <= tle_pkg::WERASE_RESET;
    end else begin
      eof_r    <= eof_nxt;
      erase_r  <= erase_nxt;
      kill_r   <= kill_nxt;
      werase_r <= werase_nxt;
    end
  end

  // Classify the typed byte; the column-zero test for end of input is left to the back end
  always_comb begin
    cmd_d.eof_hit = (in_byte == eof_r);
    cmd_d.data    = in_byte;
    if (in_byte == tle_pkg::CHAR_NL) begin
      cmd_d.op = tle_pkg::OP_NEWLINE;
    end else if (in_byte == erase_r) begin
      cmd_d.op = tle_pkg::OP_ERASE;
    end else if (in_byte == kill_r) begin
      cmd_d.op = tle_pkg::OP_KILL;
    end else if (in_byte == werase_r) begin
      cmd_d.op = tle_pkg::OP_WERASE;
    end else if (in_byte >= tle_pkg::CHAR_SPACE && in_byte <= tle_pkg::CHAR_TILDE) begin
      cmd_d.op = tle_pkg::OP_PRINT;
    end else begin
      cmd_d.op = tle_pkg::OP_BELL;
    end
  end

  // Transfer into the command queue
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

endmodule

// ===== rtl/tle_cmdq.sv =====
module tle_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tle_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output tle_pkg::cmd_t dout,
  output logic          empty
);

  localparam int DEPTH = tle_pkg::CMDQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tle_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/tle_back.sv =====
module tle_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_empty,
  input  tle_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output tle_pkg::res_t res_d
);

  typedef struct packed {
    logic                      found;
    logic [tle_pkg::COL_W-1:0] idx;
  } enc_t;

  // Highest column below limit whose space mark equals want
  function automatic enc_t find_last(input logic [tle_pkg::LINE_WIDTH-1:0] marks,
                                     input logic [tle_pkg::COL_W-1:0]      limit,
                                     input logic                           want);
    enc_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = 0; i < tle_pkg::LINE_WIDTH; i++) begin
      if (i < int'(limit) && marks[i] == want) begin
        r.found = 1'b1;
        r.idx   = tle_pkg::COL_W'(i);
      end
    end
    return r;
  endfunction

  tle_pkg::back_state_t            state_r, state_nxt;
  logic [tle_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [tle_pkg::COL_W-1:0]       c1_r, c1_nxt;
  logic                            halted_r, halted_nxt;
  logic [tle_pkg::LINE_WIDTH-1:0]  marks_r;
  tle_pkg::res_t                   pend_r, pend_nxt;
  logic                            mark_we;

  logic                            go;
  logic                            col_zero;
  logic                            col_last;
  logic                            eof_now;
  enc_t                            enc1, enc2;
  logic [tle_pkg::COL_W-1:0]       new_col;
  logic [tle_pkg::COL_W-1:0]       wcount;

  assign go       = !cmd_empty && !res_full;
  assign col_zero = (col_r == '0);
  assign col_last = (col_r == tle_pkg::COL_W'(tle_pkg::LINE_WIDTH - 1));
  assign eof_now  = cmd.eof_hit && col_zero;

  // Word erase: first skip trailing spaces, then the word
  assign enc1    = find_last(marks_r, col_r, 1'b0);
  assign enc2    = find_last(marks_r, c1_r, 1'b1);
  assign new_col = enc2.found ? enc2.idx + tle_pkg::COL_W'(1) : '0;
  assign wcount  = col_r - new_col;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tle_pkg::ST_IDLE: begin
        if (go && !halted_r && !eof_now) begin
          if (cmd.op == tle_pkg::OP_WERASE) begin
            state_nxt = tle_pkg::ST_SCAN;
          end else if (cmd.op == tle_pkg::OP_PRINT && col_last) begin
            state_nxt = tle_pkg::ST_EMIT2;
          end
        end
      end
      tle_pkg::ST_SCAN: begin
        if (!res_full) begin
          state_nxt = (wcount == '0) ? tle_pkg::ST_IDLE : tle_pkg::ST_EMIT2;
        end
      end
      tle_pkg::ST_EMIT2: begin
        if (!res_full) begin
          state_nxt = tle_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tle_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates
  always_comb begin
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    res_d      = '{kind: tle_pkg::KIND_BYTE, data: 8'd0, count: '0, last: 1'b1};
    col_nxt    = col_r;
    c1_nxt     = c1_r;
    halted_nxt = halted_r;
    pend_nxt   = pend_r;
    mark_we    = 1'b0;
    case (state_r)
      tle_pkg::ST_IDLE: begin
        if (go) begin
          cmd_pop = 1'b1;
          if (!halted_r) begin
            if (eof_now) begin
              halted_nxt = 1'b1;
              res_push   = 1'b1;
              res_d.kind = tle_pkg::KIND_EOF;
            end else begin
              case (cmd.op)
                tle_pkg::OP_NEWLINE: begin
                  res_push   = 1'b1;
                  res_d.data = tle_pkg::CHAR_NL;
                  col_nxt    = '0;
                end
                tle_pkg::OP_ERASE: begin
                  if (!col_zero) begin
                    res_push    = 1'b1;
                    res_d.kind  = tle_pkg::KIND_RUBOUT;
                    res_d.count = tle_pkg::CNT_W'(1);
                    col_nxt     = col_r - tle_pkg::COL_W'(1);
                  end
                end
                tle_pkg::OP_KILL: begin
                  if (!col_zero) begin
                    res_push    = 1'b1;
                    res_d.kind  = tle_pkg::KIND_RUBOUT;
                    res_d.count = tle_pkg::CNT_W'(col_r);
                    col_nxt     = '0;
                  end
                end
                tle_pkg::OP_WERASE: begin
                  c1_nxt = enc1.found ? enc1.idx + tle_pkg::COL_W'(1) : '0;
                end
                tle_pkg::OP_PRINT: begin
                  mark_we    = 1'b1;
                  res_push   = 1'b1;
                  res_d.data = cmd.data;
                  if (col_last) begin
                    res_d.last = 1'b0;
                    col_nxt    = '0;
                    pend_nxt   = '{kind: tle_pkg::KIND_BYTE, data: tle_pkg::CHAR_NL,
                                   count: '0, last: 1'b1};
                  end else begin
                    col_nxt = col_r + tle_pkg::COL_W'(1);
                  end
                end
                default: begin
                  res_push   = 1'b1;
                  res_d.data = tle_pkg::CHAR_BEL;
                end
              endcase
            end
          end
        end
      end
      tle_pkg::ST_SCAN: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (wcount == '0) begin
            res_d.kind = tle_pkg::KIND_CLEAR;
          end else begin
            res_d.kind  = tle_pkg::KIND_RUBOUT;
            res_d.count = tle_pkg::CNT_W'(wcount);
            res_d.last  = 1'b0;
            col_nxt     = new_col;
            pend_nxt    = '{kind: tle_pkg::KIND_CLEAR, data: 8'd0, count: '0, last: 1'b1};
          end
        end
      end
      tle_pkg::ST_EMIT2: begin
        if (!res_full) begin
          res_push = 1'b1;
          res_d    = pend_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tle_pkg::ST_IDLE;
      col_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Hold scan column, pending result and space marks
  always_ff @(posedge clk) begin
    c1_r   <= c1_nxt;
    pend_r <= pend_nxt;
    if (mark_we) begin
      marks_r[col_r] <= (cmd.data == tle_pkg::CHAR_SPACE);
    end
  end

endmodule

// ===== rtl/tle_resq.sv =====
module tle_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tle_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output tle_pkg::res_t dout,
  output logic          empty
);

  localparam int DEPTH = tle_pkg::RESQ_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tle_pkg::res_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/terminal_line_editor.sv =====
// Terminal line editor: turns typed bytes into echo, rubout, clear and
// end-of-input results for a console.
// Input channel: drive in_byte with push; the byte transfers on a clock
// edge where push is high and full is low.
// Result channel: while empty is low the oldest result sits on out_kind,
// out_byte, out_rubout_count and out_last; it transfers on an edge where
// pop is high. out_last marks the final result of one typed byte.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 eof,
// 1 erase, 2 kill, 3 word erase) at the clock edge; the user must do so
// only while idle; the block itself does not enforce this.
// A transferred byte is registered in the command queue and its results
// in the result queue; word erase scans the space marks in the idle and
// scan states; its second result and a full line's newline come from ST_EMIT2.
// A two-entry command queue decouples input from the back end, and a
// two-entry result queue decouples the back end from the receiver. When
// pop stays low the result queue fills, the back end stops, and full rises
// once the command queue is full.
// Reset (rst_n low, synchronous): both queues empty, column zero, the
// block not halted, registers at their defaults. After end of input every
// later byte is taken and dropped until reset.
module terminal_line_editor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_byte,
  output logic       full,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [5:0] out_rubout_count,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  tle_pkg::cmd_t cmd_d, cmd_q;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  tle_pkg::res_t res_d, res_q;
  logic          res_push, res_full;

  tle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .in_byte   (in_byte),
    .full      (full),
    .cmd_push  (cmd_push),
    .cmd_d     (cmd_d),
    .cmd_full  (cmd_full)
  );

  tle_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_d),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_q),
    .empty (cmd_empty)
  );

  tle_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_d     (res_d)
  );

  tle_resq u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_d),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_q),
    .empty (empty)
  );

  // Unpack the head result
  assign out_kind         = res_q.kind;
  assign out_byte         = res_q.data;
  assign out_rubout_count = res_q.count;
  assign out_last         = res_q.last;

endmodule

// ===== rtl/tle_checker.sv =====
module tle_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [5:0] out_rubout_count,
  input logic       out_last
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Only emit-byte results carry a byte, only rubouts carry a count
  a_field_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != tle_pkg::KIND_BYTE) |->
      (out_byte == 8'd0 && (out_kind == tle_pkg::KIND_RUBOUT || out_rubout_count == 6'd0)))
    else $error("result carries a field that its kind does not use");

  // Clear and end of input always close a byte's results
  a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == tle_pkg::KIND_EOF || out_kind == tle_pkg::KIND_CLEAR)) |->
      out_last)
    else $error("clear or end-of-input result not marked last");

  // A waiting result holds until it transfers
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_byte) &&
                          $stable(out_rubout_count) && $stable(out_last)))
    else $error("waiting result changed before transfer");

endmodule

bind terminal_line_editor tle_port_checker u_tle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .empty            (empty),
  .pop              (pop),
  .out_kind         (out_kind),
  .out_byte         (out_byte),
  .out_rubout_count (out_rubout_count),
  .out_last         (out_last)
);

// ===== tb/tle_checker.sv =====
`timescale 1ns / 1ps

// Watch both channels of the line editor, predict every result from the
// typed bytes and the character registers, and compare in transfer order.
// All sampling is done on the falling edge: inputs change only on the
// rising edge, so the values seen here are the ones the next rising edge
// will act on.
module tle_checker
  import tle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       full,
  input  logic       empty,
  input  logic       pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic [5:0] out_rubout_count,
  input  logic       out_last,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         outstanding
);

  res_t       pending_results[$];
  logic [7:0] eof_ch;
  logic [7:0] erase_ch;
  logic [7:0] kill_ch;
  logic [7:0] werase_ch;
  int         cur_col;
  logic       space_at [LINE_WIDTH];
  logic       stopped;

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic queue_result(input kind_t k, input logic [7:0] d, input int c,
                              input logic l);
    res_t r;
    r.kind  = k;
    r.data  = d;
    r.count = c[CNT_W-1:0];
    r.last  = l;
    pending_results.push_back(r);
  endtask

  // Apply one typed byte to the line state and queue what it should echo
  task automatic edit_keystroke(input logic [7:0] b);
    int n;
    n = 0;
    if (!stopped) begin
      if (cur_col >= LINE_WIDTH) cur_col = 0;
      if (b == eof_ch && cur_col == 0) begin
        stopped = 1'b1;
        queue_result(KIND_EOF, 8'd0, 0, 1'b1);
      end else if (b == CHAR_NL) begin
        cur_col = 0;
        queue_result(KIND_BYTE, CHAR_NL, 0, 1'b1);
      end else if (b == erase_ch) begin
        if (cur_col != 0) begin
          cur_col--;
          queue_result(KIND_RUBOUT, 8'd0, 1, 1'b1);
        end
      end else if (b == kill_ch) begin
        if (cur_col != 0) begin
          queue_result(KIND_RUBOUT, 8'd0, cur_col, 1'b1);
          cur_col = 0;
        end
      end else if (b == werase_ch) begin
        // skip trailing spaces, then the word in front of them
        while (cur_col > 0 && space_at[cur_col-1]) begin
          cur_col--;
          n++;
        end
        while (cur_col > 0 && !space_at[cur_col-1]) begin
          cur_col--;
          n++;
        end
        if (n != 0) queue_result(KIND_RUBOUT, 8'd0, n, 1'b0);
        queue_result(KIND_CLEAR, 8'd0, 0, 1'b1);
      end else if (b >= CHAR_SPACE && b <= CHAR_TILDE) begin
        space_at[cur_col] = (b == CHAR_SPACE);
        cur_col++;
        if (cur_col >= LINE_WIDTH) begin
          // full line: echo, then wrap with a forced newline
          cur_col = 0;
          queue_result(KIND_BYTE, b, 0, 1'b0);
          queue_result(KIND_BYTE, CHAR_NL, 0, 1'b1);
        end else begin
          queue_result(KIND_BYTE, b, 0, 1'b1);
        end
      end else begin
        queue_result(KIND_BYTE, CHAR_BEL, 0, 1'b1);
      end
    end
  endtask

  always @(negedge clk) begin
    res_t want;
    if (!rst_n) begin
      eof_ch    = EOF_RESET;
      erase_ch  = ERASE_RESET;
      kill_ch   = KILL_RESET;
      werase_ch = WERASE_RESET;
      cur_col   = 0;
      stopped   = 1'b0;
      foreach (space_at[i]) space_at[i] = 1'b0;
      pending_results.delete();
    end else begin
      // register writes land at the coming edge
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_EOF:    eof_ch    = cfg_data;
          REG_ERASE:  erase_ch  = cfg_data;
          REG_KILL:   kill_ch   = cfg_data;
          REG_WERASE: werase_ch = cfg_data;
          default:    ;
        endcase
      end

      // compare a result transfer with the oldest prediction
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending: kind %0d byte %0d count %0d last %0b",
                                  out_kind, out_byte, out_rubout_count, out_last));
        end else begin
          want = pending_results.pop_front();
          if (out_kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, predicted %0d", out_kind, want.kind));
          if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %0d, predicted %0d", out_byte, want.data));
          if (out_rubout_count !== want.count)
            flag_mismatch($sformatf("rubout_count %0d, predicted %0d", out_rubout_count,
                                    want.count));
          if (out_last !== want.last)
            flag_mismatch($sformatf("last %0b, predicted %0b", out_last, want.last));
        end
      end

      // predict for a byte transfer
      if (push && !full) edit_keystroke(in_byte);
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== tb/tb_terminal_line_editor.sv =====
`timescale 1ns / 1ps

module tb_terminal_line_editor;
  import tle_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 240;
  localparam int SETTLE_CYCLES = 12;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       push             = 1'b0;
  logic [7:0] in_byte          = 8'd0;
  logic       pop              = 1'b0;
  logic       cfg_we           = 1'b0;
  logic [1:0] cfg_index        = 2'd0;
  logic [7:0] cfg_data         = 8'd0;
  logic       full;
  logic       empty;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic [5:0] out_rubout_count;
  logic       out_last;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  int items_sent  = 0;
  int tx_pct      = 0;
  int rx_pct      = 0;

  // Character settings currently loaded, used to shape the stimulus
  logic [7:0] eof_c    = EOF_RESET;
  logic [7:0] erase_c  = ERASE_RESET;
  logic [7:0] kill_c   = KILL_RESET;
  logic [7:0] werase_c = WERASE_RESET;

  terminal_line_editor u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .in_byte          (in_byte),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_rubout_count (out_rubout_count),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  tle_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .in_byte          (in_byte),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_rubout_count (out_rubout_count),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result side at the current rate
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= rx_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte, idling first at the current rate, and hold it until it transfers
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    @(negedge clk);
    while (full) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Printable byte that matches none of the loaded characters
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    while (c == eof_c || c == erase_c || c == kill_c || c == werase_c)
      c = 8'($urandom_range(33, 126));
    return c;
  endfunction

  // Type a byte; the end-of-input byte only ever goes in mid-line so the
  // editor keeps running until the final phase
  task automatic type_byte(input logic [7:0] b);
    if (b == eof_c) begin
      put_byte(CHAR_NL);
      put_byte(plain_char());
    end
    put_byte(b);
  endtask

  // Keystroke mix: mostly words and spaces, with editing keys and noise
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      return 8'($urandom_range(33, 126));
    else if (r < 62) return CHAR_SPACE;
    else if (r < 68) return erase_c;
    else if (r < 72) return kill_c;
    else if (r < 77) return werase_c;
    else if (r < 81) return CHAR_NL;
    else if (r < 86) return 8'($urandom_range(0, 31));
    else if (r < 91) return 8'($urandom_range(127, 255));
    else             return 8'($urandom_range(0, 255));
  endfunction

  // Drop push, wait for every predicted result, then let the pipe empty
  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load all four characters on consecutive edges
  task automatic set_chars(input logic [7:0] e, input logic [7:0] r, input logic [7:0] k,
                           input logic [7:0] w);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EOF;
    cfg_data  <= e;
    @(posedge clk);
    cfg_index <= REG_ERASE;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= REG_KILL;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= REG_WERASE;
    cfg_data  <= w;
    @(posedge clk);
    cfg_we   <= 1'b0;
    eof_c    = e;
    erase_c  = r;
    kill_c   = k;
    werase_c = w;
  endtask

  // Random typing under one idling mode; optionally hold off mid-phase
  // until every result is back
  task automatic run_phase(input int tx, input int rx, input bit hold_mid);
    int  first;
    int  n;
    bit  held;
    first  = items_sent;
    held   = 1'b0;
    tx_pct = tx;
    rx_pct = rx;
    while (items_sent - first < PHASE_ITEMS) begin
      if (hold_mid && !held && items_sent - first >= PHASE_ITEMS / 2) begin
        settle();
        held = 1'b1;
      end
      if ($urandom_range(0, 99) < 3) begin
        // long typing run to reach the line limit
        n = $urandom_range(20, 45);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) type_byte(CHAR_SPACE);
          else type_byte(8'($urandom_range(33, 126)));
        end
      end else begin
        type_byte(pick_byte());
      end
    end
    settle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: editing keys at column zero, control and high bytes,
    // a word erase across spaces, kill, end-of-input byte typed mid-line
    type_byte(ERASE_RESET);
    type_byte(KILL_RESET);
    type_byte(WERASE_RESET);
    type_byte(CHAR_NL);
    type_byte(8'd0);
    type_byte(8'd255);
    type_byte(8'd128);
    type_byte(8'd31);
    type_byte(CHAR_SPACE);
    type_byte(CHAR_TILDE);
    type_byte("a");
    type_byte("b");
    type_byte(CHAR_SPACE);
    type_byte(CHAR_SPACE);
    type_byte(WERASE_RESET);
    type_byte(ERASE_RESET);
    type_byte("x");
    type_byte(KILL_RESET);
    type_byte(EOF_RESET);
    settle();

    run_phase(0, 0, 1'b0);
    set_chars(8'd255, 8'd0, 8'd8, 8'd255);
    run_phase(47, 0, 1'b0);
    // erase on the newline code, kill at the top code
    set_chars(8'd0, CHAR_NL, 8'd255, 8'd127);
    run_phase(0, 47, 1'b1);
    // erase and kill on the same code, word erase on zero
    set_chars(8'd4, 8'd255, 8'd255, 8'd0);
    run_phase(32, 32, 1'b0);
    // printable end-of-input byte, space as word erase
    set_chars("q", 8'd8, 8'd0, CHAR_SPACE);
    run_phase(32, 32, 1'b0);
    set_chars(EOF_RESET, ERASE_RESET, KILL_RESET, WERASE_RESET);
    run_phase(47, 0, 1'b0);

    // End input at column zero; everything after it is dropped
    put_byte(CHAR_NL);
    put_byte(eof_c);
    repeat (6) put_byte(8'($urandom_range(0, 255)));
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
